// ----- design/rtp_hp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rtp_hp_pkg;

  // Packet size limits
  localparam int unsigned MaxPacketBytes   = 65535;
  localparam int unsigned FixedHeaderBytes = 12;

  // Header byte zero fields, and the payload type mask for header byte one
  localparam logic [7:0] VersionMask = 8'hC0;
  localparam logic [7:0] VersionTwo  = 8'h80;
  localparam logic [7:0] PadBit      = 8'h20;
  localparam logic [7:0] ExtBit      = 8'h10;
  localparam logic [7:0] CcMask      = 8'h0F;
  localparam logic [7:0] PtMask      = 8'h7F;

  // Internal width of the payload offset sum before saturation
  localparam int unsigned OffW = 19;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_PAD_LARGE = 3'd2,
    ST_BAD_VER   = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic        marker;
    logic [6:0]  payload_type;
    logic        padding_flag;
    logic        extension_flag;
    logic [3:0]  csrc_count;
    logic [15:0] sequence_number;
    logic [31:0] timestamp;
    logic [31:0] ssrc;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [2:0]  status;
  } desc_item_t;

endpackage

`default_nettype wire

// ----- design/rtp_hp_byte_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rtp_hp_byte_if
  import rtp_hp_pkg::*;
();
  logic       valid;
  logic       ready;
  byte_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/rtp_hp_desc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rtp_hp_desc_if
  import rtp_hp_pkg::*;
();
  logic       valid;
  logic       ready;
  desc_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/rtp_header_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Item                         Fields
// byte_if   in   one packet byte              data_byte, last_byte
// desc_if   out  one descriptor per packet    header fields, offset, length, status
//
// One byte is taken per cycle, back to back, while byte_if.ready is high. The edge that
// takes the last byte loads the packet snapshot register; the output register is then
// loaded from the offset/length/status logic when it is free and offers the descriptor.
// Reset clears the per-packet state and both valid flags.
// A stalled descriptor holds the output register; bytes keep flowing until the
// snapshot register is also full, then byte_if.ready drops.

module rtp_header_parser
  import rtp_hp_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytes
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  rtp_hp_byte_if.sink   byte_if,
  rtp_hp_desc_if.source desc_if
);

  // Per-packet state
  logic [15:0] byte_count_q, byte_count_d;
  logic [7:0]  hdr0_q, hdr0_d;
  logic [7:0]  hdr1_q, hdr1_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] ts_q, ts_d;
  logic [31:0] ssrc_q, ssrc_d;
  logic [15:0] ext_q, ext_d;
  logic        ovf_q, ovf_d;

  // Snapshot stage
  logic        snap_valid_q;
  logic [15:0] snap_len_q;
  logic [7:0]  snap_hdr0_q;
  logic [7:0]  snap_hdr1_q;
  logic [15:0] snap_seq_q;
  logic [31:0] snap_ts_q;
  logic [31:0] snap_ssrc_q;
  logic [15:0] snap_ext_q;
  logic        snap_ovf_q;
  logic [7:0]  snap_last_q;

  // Output register
  logic       out_valid_q;
  desc_item_t out_q;

  logic       out_free, snap_free, byte_acc, last_acc;
  logic [7:0] b;
  logic [15:0] ext_pos;

  assign out_free  = !out_valid_q || desc_if.ready;
  assign snap_free = !snap_valid_q || out_free;
  assign byte_if.ready = snap_free;
  assign byte_acc  = byte_if.valid && snap_free;
  assign last_acc  = byte_acc && byte_if.payload.last_byte;
  assign b         = byte_if.payload.data_byte;
  assign ext_pos   = 16'(FixedHeaderBytes) + {10'd0, hdr0_q[3:0], 2'b00} + 16'd2;

  // Capture header bytes by position, count bytes up to the limit
  always_comb begin
    hdr0_d = hdr0_q;
    hdr1_d = hdr1_q;
    seq_d  = seq_q;
    ts_d   = ts_q;
    ssrc_d = ssrc_q;
    ext_d  = ext_q;
    if (byte_count_q == 16'd0) begin
      hdr0_d = b;
    end else if (byte_count_q == 16'd1) begin
      hdr1_d = b;
    end else if (byte_count_q < 16'd4) begin
      seq_d = {seq_q[7:0], b};
    end else if (byte_count_q < 16'd8) begin
      ts_d = {ts_q[23:0], b};
    end else if (byte_count_q < 16'(FixedHeaderBytes)) begin
      ssrc_d = {ssrc_q[23:0], b};
    end else if (byte_count_q == ext_pos || byte_count_q == ext_pos + 16'd1) begin
      ext_d = {ext_q[7:0], b};
    end
    if (byte_count_q >= 16'(MAX_PACKET_BYTES)) begin
      ovf_d        = 1'b1;
      byte_count_d = byte_count_q;
    end else begin
      ovf_d        = ovf_q;
      byte_count_d = byte_count_q + 16'd1;
    end
  end

  // Advance per-packet state, clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      hdr0_q       <= '0;
      hdr1_q       <= '0;
      seq_q        <= '0;
      ts_q         <= '0;
      ssrc_q       <= '0;
      ext_q        <= '0;
      ovf_q        <= 1'b0;
    end else if (byte_acc) begin
      if (byte_if.payload.last_byte) begin
        byte_count_q <= '0;
        hdr0_q       <= '0;
        hdr1_q       <= '0;
        seq_q        <= '0;
        ts_q         <= '0;
        ssrc_q       <= '0;
        ext_q        <= '0;
        ovf_q        <= 1'b0;
      end else begin
        byte_count_q <= byte_count_d;
        hdr0_q       <= hdr0_d;
        hdr1_q       <= hdr1_d;
        seq_q        <= seq_d;
        ts_q         <= ts_d;
        ssrc_q       <= ssrc_d;
        ext_q        <= ext_d;
        ovf_q        <= ovf_d;
      end
    end
  end

  // Snapshot the finished packet on its last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (snap_free) begin
      snap_valid_q <= last_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_acc) begin
      snap_len_q  <= byte_count_d;
      snap_hdr0_q <= hdr0_d;
      snap_hdr1_q <= hdr1_d;
      snap_seq_q  <= seq_d;
      snap_ts_q   <= ts_d;
      snap_ssrc_q <= ssrc_d;
      snap_ext_q  <= ext_d;
      snap_ovf_q  <= ovf_d;
      snap_last_q <= b;
    end
  end

  // Work out offset, padding, length and status
  logic            padf, extf;
  logic [OffW-1:0] off, pad, len, off_pad;
  status_e         status;
  logic [OffW-1:0] plen;
  desc_item_t      desc_d;

  always_comb begin
    padf    = (snap_hdr0_q & PadBit) != 8'd0;
    extf    = (snap_hdr0_q & ExtBit) != 8'd0;
    len     = OffW'(snap_len_q);
    pad     = padf ? OffW'(snap_last_q) : '0;
    off     = OffW'(FixedHeaderBytes) + OffW'({snap_hdr0_q[3:0], 2'b00});
    if (extf) begin
      off = off + OffW'(4) + OffW'({snap_ext_q, 2'b00});
    end
    off_pad = off + pad;

    if (snap_ovf_q) begin
      status = ST_TOO_LONG;
    end else if (len < OffW'(FixedHeaderBytes)) begin
      status = ST_SHORT;
    end else if ((snap_hdr0_q & VersionMask) != VersionTwo) begin
      status = ST_BAD_VER;
    end else if (len < off) begin
      status = ST_SHORT;
    end else if (padf && (pad >= len - OffW'(FixedHeaderBytes) || off_pad > len)) begin
      status = ST_PAD_LARGE;
    end else begin
      status = ST_OK;
    end

    if (status == ST_OK && len > off_pad) begin
      plen = len - off_pad;
    end else begin
      plen = '0;
    end

    desc_d.marker          = snap_hdr1_q[7];
    desc_d.payload_type    = snap_hdr1_q[6:0] & PtMask[6:0];
    desc_d.padding_flag    = padf;
    desc_d.extension_flag  = extf;
    desc_d.csrc_count      = snap_hdr0_q[3:0] & CcMask[3:0];
    desc_d.sequence_number = snap_seq_q;
    desc_d.timestamp       = snap_ts_q;
    desc_d.ssrc            = snap_ssrc_q;
    desc_d.payload_offset  = (off > OffW'(16'hFFFF)) ? 16'hFFFF : off[15:0];
    desc_d.payload_length  = plen[15:0];
    desc_d.status          = status;
  end

  // Hold the descriptor until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && snap_valid_q) begin
      out_q <= desc_d;
    end
  end

  assign desc_if.valid   = out_valid_q;
  assign desc_if.payload = out_q;

  // Checks
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= 16'(MAX_PACKET_BYTES))
    else $error("byte count past limit");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |=> (byte_count_q == 16'd0 && !ovf_q))
    else $error("packet state not cleared after last byte");

  a_bad_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |-> out_q.payload_length == 16'd0)
    else $error("payload length on a flagged packet");

  a_snap_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid_q && out_free) |=> out_valid_q)
    else $error("snapshot lost on its way to output");

endmodule

`default_nettype wire
